[hdl/mwis_pkg.sv]
// Shared constants, state types and unit status struct for the Moebius-weighted isqrt sum block.
package mwis_pkg;

  localparam int NUMBER_WIDTH_DEFAULT = 32;
  localparam int BOUND_BITS           = 62;
  localparam int TOTAL_BITS           = 53;
  localparam int ROOT_BITS            = BOUND_BITS / 2;
  localparam int MU_BITS              = 2;

  // Moebius codes that contribute to the sum; zero and the unused code add nothing.
  localparam logic [MU_BITS-1:0] MU_PLUS  = 2'b01;
  localparam logic [MU_BITS-1:0] MU_MINUS = 2'b11;

  localparam logic [BOUND_BITS-1:0] BOUND_RESET = BOUND_BITS'(1);

  typedef enum logic [1:0] {
    CALC_IDLE,
    CALC_DIV,
    CALC_SQRT
  } calc_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ACC,
    ST_EMIT
  } top_state_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } calc_res_t;

endpackage

[hdl/mwis_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface mwis_in_if #(
  parameter int NUMBER_WIDTH = mwis_pkg::NUMBER_WIDTH_DEFAULT
);
  import mwis_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [NUMBER_WIDTH-1:0]   number;
  logic signed [MU_BITS-1:0] mobius_value;
  logic                      is_last;

  modport source (output valid, output number, output mobius_value, output is_last,
                  input ready);
  modport sink (input valid, input number, input mobius_value, input is_last,
                output ready);
endinterface

interface mwis_out_if;
  import mwis_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [TOTAL_BITS-1:0] total;

  modport source (output valid, output total, input ready);
  modport sink (input valid, input total, output ready);
endinterface

[hdl/mwis_calc.sv]
// Bit-serial unit: restoring division of the bound by n, then a digit-by-digit integer square root.
module mwis_calc #(
  parameter int NUMBER_WIDTH = mwis_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mwis_pkg::BOUND_BITS-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0]       divisor,
  output mwis_pkg::calc_res_t           res
);
  import mwis_pkg::*;

  localparam int SQ_REM_BITS = ROOT_BITS + 1;
  localparam int REM_W = (NUMBER_WIDTH > SQ_REM_BITS) ? NUMBER_WIDTH : SQ_REM_BITS;
  localparam int SUB_W = REM_W + 2;
  localparam int CNT_W = $clog2(BOUND_BITS);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(BOUND_BITS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_BITS - 1);

  calc_state_t state, state_next;

  logic [CNT_W-1:0]      count;
  logic [BOUND_BITS-1:0] quo;
  logic [REM_W-1:0]      rem;
  logic [NUMBER_WIDTH-1:0] divisor_q;
  logic [ROOT_BITS-1:0]  root;
  logic                  done;

  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W:0]   sub_full;
  logic             ge;

  // The one shared subtractor serves both the division and the square root steps.
  always_comb begin
    if (state == CALC_SQRT) begin
      sub_a = SUB_W'({rem[SQ_REM_BITS-1:0], quo[BOUND_BITS-1 -: 2]});
      sub_b = SUB_W'({root, 2'b01});
    end else begin
      sub_a = {1'b0, rem, quo[BOUND_BITS-1]};
      sub_b = SUB_W'(divisor_q);
    end
    sub_full = {1'b0, sub_a} - {1'b0, sub_b};
    ge = ~sub_full[SUB_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CALC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CALC_IDLE: begin
        if (start) state_next = CALC_DIV;
      end
      CALC_DIV: begin
        if (count == DIV_LAST) state_next = CALC_SQRT;
      end
      CALC_SQRT: begin
        if (count == SQRT_LAST) state_next = CALC_IDLE;
      end
      default: state_next = CALC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == CALC_SQRT) && (count == SQRT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CALC_IDLE: begin
        if (start) begin
          quo       <= dividend;
          divisor_q <= divisor;
          rem       <= '0;
          count     <= '0;
        end
      end
      CALC_DIV: begin
        quo <= {quo[BOUND_BITS-2:0], ge};
        if (count == DIV_LAST) begin
          // The quotient is complete; the square root starts from a clean remainder.
          rem   <= '0;
          root  <= '0;
          count <= '0;
        end else begin
          rem   <= ge ? sub_full[REM_W-1:0] : sub_a[REM_W-1:0];
          count <= count + 1'b1;
        end
      end
      CALC_SQRT: begin
        quo   <= {quo[BOUND_BITS-3:0], 2'b00};
        rem   <= REM_W'(ge ? sub_full[SQ_REM_BITS-1:0] : sub_a[SQ_REM_BITS-1:0]);
        root  <= {root[ROOT_BITS-2:0], ge};
        count <= count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res.done = done;
  assign res.root = root;

endmodule

[hdl/mobius_weighted_isqrt_sum_unit.sv]
// Top level: input handshake, bound register, saturating accumulator and result register.
// An item with mu of +1 or -1 and nonzero n runs 62 division steps and then 31 square root steps
// in the one shared subtractor before the accumulate state; other items go straight to accumulate.
// An item marked last then also passes the result register state before the next acceptance.
// A new item is accepted while the previous result still waits on the output.
// Reset (synchronous, active high) sets the bound to 1 and clears the sum and output valid.
module mobius_weighted_isqrt_sum_unit #(
  parameter int NUMBER_WIDTH = mwis_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mwis_pkg::BOUND_BITS-1:0] cfg_data,
  mwis_in_if.sink                         items,
  mwis_out_if.source                      totals
);
  import mwis_pkg::*;

  top_state_t state, state_next;

  logic [BOUND_BITS-1:0]        bound_x;
  logic signed [TOTAL_BITS-1:0] running_sum;
  logic signed [TOTAL_BITS-1:0] total;
  logic                         out_valid;
  logic                         last_q;
  logic                         active_q;
  logic                         minus_q;

  logic      accept;
  logic      active_in;
  logic      start;
  logic      slot_free;
  calc_res_t calc_res;

  logic signed [TOTAL_BITS:0] sum_ext;
  logic signed [TOTAL_BITS:0] addend;
  logic signed [TOTAL_BITS-1:0] sum_sat;

  mwis_calc #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_calc (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (bound_x),
    .divisor  (items.number),
    .res      (calc_res)
  );

  assign accept    = items.valid && items.ready;
  assign active_in = (items.number != '0) &&
                     ((items.mobius_value == MU_PLUS) || (items.mobius_value == MU_MINUS));
  assign start     = accept && active_in;
  assign slot_free = !out_valid || totals.ready;

  assign items.ready  = (state == ST_IDLE);
  assign totals.valid = out_valid;
  assign totals.total = total;

  // The root is under 32 bits, so one overflow check on the widened sum is enough.
  always_comb begin
    addend  = (TOTAL_BITS + 1)'(calc_res.root);
    if (minus_q) addend = -addend;
    sum_ext = {running_sum[TOTAL_BITS-1], running_sum} + addend;
    if (sum_ext[TOTAL_BITS] != sum_ext[TOTAL_BITS-1]) begin
      sum_sat = sum_ext[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                    : {1'b0, {(TOTAL_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = active_in ? ST_CALC : ST_ACC;
      end
      ST_CALC: begin
        if (calc_res.done) state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_x <= BOUND_RESET;
    end else if (cfg_we) begin
      bound_x <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_q   <= items.is_last;
      active_q <= active_in;
      minus_q  <= (items.mobius_value == MU_MINUS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if ((state == ST_ACC) && active_q) begin
      running_sum <= sum_sat;
    end else if ((state == ST_EMIT) && slot_free) begin
      running_sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && slot_free) begin
      out_valid <= 1'b1;
    end else if (totals.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && slot_free) begin
      total <= running_sum;
    end
  end

endmodule
